@@ rtl/core/dfq_pkg.sv @@
package dfq_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int ID_W        = 15;
  localparam int CMD_ID_W    = 16;
  localparam int COUNT_W     = $clog2(QUEUE_DEPTH + 1);
  localparam int STATUS_W    = 3;
  localparam int OCC_W       = 5;

  localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
  localparam logic [STATUS_W-1:0] ST_NEGATIVE  = 3'd1;
  localparam logic [STATUS_W-1:0] ST_DUPLICATE = 3'd2;
  localparam logic [STATUS_W-1:0] ST_FULL      = 3'd3;
  localparam logic [STATUS_W-1:0] ST_EMPTY     = 3'd4;

  localparam logic CMD_PUSH = 1'b0;
  localparam logic CMD_POP  = 1'b1;

  typedef logic [ID_W-1:0] id_t;

  // per-cell control from the queue controller
  typedef struct packed {
    logic shift;     // take the neighbor's id (pop)
    logic load;      // take the pushed id
    logic occupied;  // cell holds a queued id
  } cell_ctrl_t;

endpackage

@@ rtl/core/dedup_fifo_queue_top.sv @@
// channel | direction | fields                        | handshake
// --------+-----------+-------------------------------+--------------------
// in      | input     | command, item_id              | in_valid / in_ready
// out     | output    | status, popped_id, occupancy  | out_valid / out_ready
//
// one word per cycle unless the output stalls: every cell compares its id with
// the pushed id in the same cycle, and a pop shifts the whole row by one cell
// toward the head. a result is held in the output register once its word is
// taken; a new word is taken whenever that register is empty or drains.
// synchronous reset empties the queue; cell contents are not cleared.
module dedup_fifo_queue_top (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              command,
  input  logic signed [dfq_pkg::CMD_ID_W-1:0] item_id,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [dfq_pkg::STATUS_W-1:0]      status,
  output logic [dfq_pkg::ID_W-1:0]          popped_id,
  output logic [dfq_pkg::OCC_W-1:0]         occupancy
);

  logic [dfq_pkg::COUNT_W-1:0] count;
  logic [dfq_pkg::COUNT_W-1:0] count_next;
  logic [dfq_pkg::STATUS_W-1:0] status_next;
  logic [dfq_pkg::ID_W-1:0]     popped_next;
  logic                         take;
  logic                         do_push;
  logic                         do_pop;
  logic                         dup;
  dfq_pkg::id_t                 probe_id;

  dfq_pkg::cell_ctrl_t          ctrl   [dfq_pkg::QUEUE_DEPTH];
  dfq_pkg::id_t                 ids    [dfq_pkg::QUEUE_DEPTH];
  logic [dfq_pkg::QUEUE_DEPTH-1:0] hits;

  assign in_ready = !out_valid || out_ready;
  assign take     = in_valid && in_ready;
  assign probe_id = item_id[dfq_pkg::ID_W-1:0];
  assign dup      = |hits;

  always_comb begin
    status_next = dfq_pkg::ST_OK;
    popped_next = '0;
    count_next  = count;
    do_push     = 1'b0;
    do_pop      = 1'b0;
    if (command == dfq_pkg::CMD_PUSH) begin
      if (item_id[dfq_pkg::CMD_ID_W-1]) begin
        status_next = dfq_pkg::ST_NEGATIVE;
      end else if (dup) begin
        status_next = dfq_pkg::ST_DUPLICATE;
      end else if (count == dfq_pkg::COUNT_W'(dfq_pkg::QUEUE_DEPTH)) begin
        status_next = dfq_pkg::ST_FULL;
      end else begin
        do_push    = 1'b1;
        count_next = count + 1'b1;
      end
    end else begin
      if (count == '0) begin
        status_next = dfq_pkg::ST_EMPTY;
      end else begin
        do_pop      = 1'b1;
        popped_next = ids[0];
        count_next  = count - 1'b1;
      end
    end
  end

  for (genvar k = 0; k < dfq_pkg::QUEUE_DEPTH; k++) begin : g_cell
    dfq_pkg::id_t nbr_id;

    always_comb begin
      ctrl[k].occupied = dfq_pkg::COUNT_W'(k) < count;
      ctrl[k].shift    = take && do_pop;
      ctrl[k].load     = take && do_push && (dfq_pkg::COUNT_W'(k) == count);
    end

    // last cell has no neighbor; what it takes on a pop lies beyond the count
    if (k == dfq_pkg::QUEUE_DEPTH - 1) begin : g_tail
      assign nbr_id = '0;
    end else begin : g_mid
      assign nbr_id = ids[k+1];
    end

    dfq_cell u_cell (
      .clk      (clk),
      .ctrl     (ctrl[k]),
      .probe_id (probe_id),
      .next_id  (nbr_id),
      .cell_id  (ids[k]),
      .match    (hits[k])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (take) begin
        count     <= count_next;
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      status    <= status_next;
      popped_id <= popped_next;
      occupancy <= dfq_pkg::OCC_W'(count_next);
    end
  end

endmodule

@@ rtl/core/dfq_cell.sv @@
module dfq_cell (
  input  logic              clk,
  input  dfq_pkg::cell_ctrl_t ctrl,
  input  dfq_pkg::id_t      probe_id,
  input  dfq_pkg::id_t      next_id,
  output dfq_pkg::id_t      cell_id,
  output logic              match
);

  dfq_pkg::id_t slot_id;

  always_ff @(posedge clk) begin
    if (ctrl.shift) begin
      slot_id <= next_id;
    end else if (ctrl.load) begin
      slot_id <= probe_id;
    end
  end

  assign cell_id = slot_id;
  assign match   = ctrl.occupied && (slot_id == probe_id);

endmodule
